FILE: design/jtok_pkg.sv
// jtok_pkg: shared constants, codes and types of the streaming JSON tokenizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package jtok_pkg;

	// default sizing, handed down from the top level parameters
	localparam int MAX_TOKENS_DEF    = 64;
	localparam int POSITION_BITS_DEF = 16;

	// fixed field widths
	localparam int BYTE_W   = 8;
	localparam int CFG_W    = 7;
	localparam int KIND_W   = 2;
	localparam int CHILD_W  = 6;
	localparam int STATUS_W = 3;

	localparam logic [CFG_W-1:0] MAX_TOKENS_RST = 7'd64;

	// result queue: one lane per possible record of one input word
	localparam int RESQ_DEPTH = 8;
	localparam int PUSH_LANES = 4;
	localparam int MAX_PUSH   = 3;

	// token kinds
	localparam logic [KIND_W-1:0] KIND_OBJECT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ARRAY  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STRING = 2'd2;
	localparam logic [KIND_W-1:0] KIND_PRIM   = 2'd3;

	// record kinds
	localparam logic REC_TOKEN = 1'b0;
	localparam logic REC_DONE  = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_TOKENS = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_CLOSE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd4;

	// characters
	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
	localparam logic [BYTE_W-1:0] CH_LOW_F  = 8'h66;
	localparam logic [BYTE_W-1:0] CH_LOW_N  = 8'h6E;
	localparam logic [BYTE_W-1:0] CH_LOW_T  = 8'h74;
	localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;

	// scanner state
	typedef enum logic [3:0] {
		MODE_OUT  = 4'b0001,
		MODE_STR  = 4'b0010,
		MODE_ESC  = 4'b0100,
		MODE_PRIM = 4'b1000
	} scan_mode_t;

	// token table access strobes
	typedef struct packed {
		logic desc_we;
		logic cnt_we;
		logic rd_en;
	} tab_ctl_t;

endpackage

FILE: design/jtok_table.sv
// jtok_table: token table, a descriptor memory and a child count memory,
// one write port each, one shared read address, registered read data. Uses jtok_pkg.
`timescale 1ns / 1ps

module jtok_table import jtok_pkg::*; #(
	parameter int DEPTH  = MAX_TOKENS_DEF,
	parameter int DESC_W = 8,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  tab_ctl_t           ctl,
	input  logic [AW-1:0]      desc_waddr,
	input  logic [DESC_W-1:0]  desc_wdata,
	input  logic [AW-1:0]      cnt_waddr,
	input  logic [CHILD_W-1:0] cnt_wdata,
	input  logic [AW-1:0]      raddr,
	output logic [DESC_W-1:0]  desc_rdata,
	output logic [CHILD_W-1:0] cnt_rdata
);

	logic [DESC_W-1:0]  desc_mem [DEPTH];
	logic [CHILD_W-1:0] cnt_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.desc_we) begin
			desc_mem[desc_waddr] <= desc_wdata;
		end
		if (ctl.rd_en) begin
			desc_rdata <= desc_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (ctl.rd_en) begin
			cnt_rdata <= cnt_mem[raddr];
		end
	end

endmodule

FILE: design/jtok_resq.sv
// jtok_resq: result queue; takes up to LANES records per cycle in lane order,
// hands out one per ready cycle. DEPTH must be a power of two. Uses jtok_pkg.
`timescale 1ns / 1ps

module jtok_resq import jtok_pkg::*; #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = RESQ_DEPTH,
	parameter int LANES  = PUSH_LANES,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [LANES-1:0]            push_v,
	input  logic [LANES-1:0][WIDTH-1:0] push_data,
	output logic                        in_room,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [WIDTH-1:0]            out_data
);

	logic [WIDTH-1:0]            mem_q [DEPTH];
	logic [PTR_W-1:0]            wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [LANES-1:0][PTR_W-1:0] waddr;
	logic [CNT_W-1:0]            n_push;
	logic                        pop;

	// valid lanes pack densely behind the write pointer
	always_comb begin
		n_push = '0;
		for (int i = 0; i < LANES; i++) begin
			waddr[i] = wr_ptr_q + PTR_W'(n_push);
			n_push = n_push + CNT_W'(push_v[i]);
		end
	end

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign in_room   = (cnt_q <= CNT_W'(DEPTH - MAX_PUSH));
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			if (push_v[i]) begin
				mem_q[waddr[i]] <= push_data[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			cnt_q    <= cnt_q + n_push - CNT_W'(pop);
		end
	end

endmodule

FILE: design/json_tokenizer.sv
// Streaming JSON tokenizer. One text byte enters per word on the s_axis side
// (tlast marks the last byte of a document; a zero byte also ends it). As each
// object, array, string or primitive completes, a token record leaves on the
// m_axis side with its index, kind, start, end (exclusive), parent (-1 at top
// level) and child count; at each document end a done record (tuser = 1)
// carries the token total and the status (0 ok, 1 out of tokens, 2 bad close,
// 3 invalid byte, 4 too long). tlast marks the final record caused by a byte.
// Throughput: one byte per clock. A byte causes zero to three records; the
// result queue drains one per clock while m_axis_tready is high, and input
// stalls only while it holds fewer than three free slots. The token table
// is a pair of synchronous memories with registered read data. Only closing
// a container reads it: the parent's entry is fetched in the close cycle
// and used straight from the read register in the next, so closes run back
// to back. The open container's entry sits in a cache register: its
// descriptor is written to memory when it opens, its child count is written
// back when a child container opens.
// max_tokens (cfg port) is the per-document token
// limit, clipped to MAX_TOKENS; write it only while idle. No clearing pass
// after reset: table entries are always written before they are read.
// Depends on jtok_pkg, jtok_table and jtok_resq.
`timescale 1ns / 1ps

module json_tokenizer import jtok_pkg::*; #(
	parameter int MAX_TOKENS     = MAX_TOKENS_DEF,
	parameter int POSITION_BITS  = POSITION_BITS_DEF,
	localparam int IDX_W    = $clog2(MAX_TOKENS),
	localparam int CNT_W    = $clog2(MAX_TOKENS + 1),
	localparam int PAR_W    = IDX_W + 1,
	localparam int FIELDS_W = IDX_W + KIND_W + 2 * POSITION_BITS + CHILD_W + PAR_W
		+ CNT_W + STATUS_W,
	localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// config write: max_tokens
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_data,
	// text in
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [BYTE_W-1:0]  s_axis_tdata,   // text_byte
	input  logic               s_axis_tlast,   // doc_end
	// records out
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,   // token_index, token_kind, start_pos,
	                                           // end_pos, child_count, parent_index,
	                                           // token_total, status, zero pad
	output logic [0:0]         m_axis_tuser,   // record_kind
	output logic               m_axis_tlast    // last_of_run
);

	localparam int PB     = POSITION_BITS;
	localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int DESC_W = KIND_W + PB + 1 + IDX_W;
	localparam int REC_W  = FIELDS_W + 2;

	// ---------------------------------------------------------------------
	// Config register
	// ---------------------------------------------------------------------
	logic [CFG_W-1:0] cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= MAX_TOKENS_RST;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	// ---------------------------------------------------------------------
	// Scanner state
	// ---------------------------------------------------------------------
	scan_mode_t          mode_q, mode_b, mode_d;
	logic [STATUS_W-1:0] err_q, err_b, err_d;
	logic [CNT_W-1:0]    next_q, next_b, next_d;
	logic [PB-1:0]       pos_q, pos_b, pos_d;
	logic [PB-1:0]       open_start_q, open_start_b, open_start_d;
	logic [IDX_W-1:0]    open_idx_q, open_idx_b, open_idx_d;
	// innermost open container (super token)
	logic                sup_none_q, sup_none_b, sup_none_d;
	logic [IDX_W-1:0]    sup_idx_q, sup_idx_b;
	logic                reload_q, reload_d;
	// cached table entry of the innermost container
	logic [KIND_W-1:0]   c_kind_q, c_kind_d;
	logic [PB-1:0]       c_start_q, c_start_d;
	logic                c_pnone_q, c_pnone_d;
	logic [IDX_W-1:0]    c_par_q, c_par_d;
	logic [CHILD_W-1:0]  c_size_q, c_size_d;

	// table port
	tab_ctl_t            tab_ctl;
	logic [DESC_W-1:0]   desc_wdata, desc_rdata;
	logic [CHILD_W-1:0]  cnt_wdata, cnt_rdata;
	logic [IDX_W-1:0]    tab_raddr;

	// current entry: straight from the read register right after a close
	logic [KIND_W-1:0]   eff_kind;
	logic [PB-1:0]       eff_start;
	logic                eff_pnone;
	logic [IDX_W-1:0]    eff_par;
	logic [CHILD_W-1:0]  eff_size, size_inc;

	assign eff_kind  = reload_q ? desc_rdata[DESC_W-1 -: KIND_W] : c_kind_q;
	assign eff_start = reload_q ? desc_rdata[IDX_W+1 +: PB]      : c_start_q;
	assign eff_pnone = reload_q ? desc_rdata[IDX_W]              : c_pnone_q;
	assign eff_par   = reload_q ? desc_rdata[IDX_W-1:0]          : c_par_q;
	assign eff_size  = reload_q ? cnt_rdata                      : c_size_q;
	assign size_inc  = (eff_size == '1) ? eff_size : eff_size + CHILD_W'(1);

	// ---------------------------------------------------------------------
	// Byte decode
	// ---------------------------------------------------------------------
	logic [BYTE_W-1:0] c;
	logic acc, is_zero, fin, take, too_long, proc;
	logic cls_space, cls_open, cls_close, cls_quote, cls_sep, cls_pstart, cls_term;
	logic cls_invalid;

	assign c       = s_axis_tdata;
	assign acc     = s_axis_tvalid && s_axis_tready;
	assign is_zero = (c == CH_NUL);
	assign fin     = acc && (is_zero || s_axis_tlast);
	assign take    = acc && !is_zero && (err_q == ST_OK);
	assign too_long = (pos_q == '1);
	assign proc    = take && !too_long;

	assign cls_space  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	assign cls_open   = (c == CH_LBRACE) || (c == CH_LBRACK);
	assign cls_close  = (c == CH_RBRACE) || (c == CH_RBRACK);
	assign cls_quote  = (c == CH_QUOTE);
	assign cls_sep    = cls_space || (c == CH_COLON) || (c == CH_COMMA);
	assign cls_pstart = ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_MINUS)
		|| (c == CH_LOW_T) || (c == CH_LOW_F) || (c == CH_LOW_N);
	assign cls_term   = cls_space || (c == CH_COMMA) || cls_close;
	assign cls_invalid = !(cls_open || cls_close || cls_quote || cls_sep || cls_pstart);

	// token limit
	logic [LIM_W-1:0] lim;
	logic alloc_ok, end_alloc_ok;

	assign lim = (LIM_W'(cfg_q) > LIM_W'(MAX_TOKENS)) ? LIM_W'(MAX_TOKENS) : LIM_W'(cfg_q);
	assign alloc_ok     = (LIM_W'(next_q) < lim);
	assign end_alloc_ok = (LIM_W'(next_b) < lim);

	// actions of this byte
	logic prim_end, outside, str_close, open_req, close_req, prim_req;
	logic push, pop, close_ok, prim_ok, str_ok, byte_alloc;
	logic end_live, end_prim, end_str, end_str_ok;
	logic [KIND_W-1:0]   open_kind, close_kind;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]    total;

	assign prim_end   = proc && (mode_q == MODE_PRIM) && cls_term;
	assign outside    = proc && ((mode_q == MODE_OUT) || prim_end);
	assign str_close  = proc && (mode_q == MODE_STR) && cls_quote;
	assign open_req   = outside && cls_open;
	assign close_req  = outside && cls_close;
	assign prim_req   = outside && cls_pstart;
	assign open_kind  = (c == CH_LBRACE) ? KIND_OBJECT : KIND_ARRAY;
	assign close_kind = (c == CH_RBRACE) ? KIND_OBJECT : KIND_ARRAY;
	assign close_ok   = !sup_none_q && (eff_kind == close_kind);
	assign push       = open_req && alloc_ok;
	assign pop        = close_req && close_ok;
	assign prim_ok    = prim_req && alloc_ok;
	assign str_ok     = str_close && alloc_ok;
	assign byte_alloc = push || prim_ok || str_ok;

	always_comb begin
		mode_b = mode_q;
		if (proc) begin
			unique case (mode_q)
				MODE_ESC: begin
					mode_b = MODE_STR;
				end
				MODE_STR: begin
					if (c == CH_BSLASH) begin
						mode_b = MODE_ESC;
					end else if (cls_quote) begin
						mode_b = MODE_OUT;
					end
				end
				MODE_PRIM: begin
					// a terminator is never a quote or a primitive start
					if (cls_term) begin
						mode_b = MODE_OUT;
					end
				end
				MODE_OUT: begin
					if (cls_quote) begin
						mode_b = MODE_STR;
					end else if (prim_ok) begin
						mode_b = MODE_PRIM;
					end
				end
				default: begin
					mode_b = MODE_OUT;
				end
			endcase
		end
	end

	always_comb begin
		if (take && too_long) begin
			err_b = ST_TOO_LONG;
		end else if ((open_req || prim_req || str_close) && !alloc_ok) begin
			err_b = ST_NO_TOKENS;
		end else if (close_req && !close_ok) begin
			err_b = ST_BAD_CLOSE;
		end else if (outside && cls_invalid) begin
			err_b = ST_INVALID;
		end else begin
			err_b = err_q;
		end
	end

	always_comb begin
		open_start_b = open_start_q;
		open_idx_b   = open_idx_q;
		if (outside && cls_quote) begin
			open_start_b = pos_q + PB'(1);
		end else if (prim_ok) begin
			open_start_b = pos_q;
			open_idx_b   = next_q[IDX_W-1:0];
		end
	end

	assign next_b = next_q + CNT_W'(byte_alloc);
	assign pos_b  = pos_q + PB'(proc);

	always_comb begin
		sup_none_b = sup_none_q;
		sup_idx_b  = sup_idx_q;
		if (push) begin
			sup_none_b = 1'b0;
			sup_idx_b  = next_q[IDX_W-1:0];
		end else if (pop) begin
			sup_none_b = eff_pnone;
			sup_idx_b  = eff_par;
		end
	end

	// document end: close a string or primitive still open unless an error came first
	assign end_live   = fin && (err_b == ST_OK);
	assign end_prim   = end_live && (mode_b == MODE_PRIM);
	assign end_str    = end_live && ((mode_b == MODE_STR) || (mode_b == MODE_ESC));
	assign end_str_ok = end_str && end_alloc_ok;
	assign status     = (end_str && !end_alloc_ok) ? ST_NO_TOKENS : err_b;
	assign total      = next_b + CNT_W'(end_str_ok);

	// next state; a document end starts the next one fresh
	assign mode_d       = fin ? MODE_OUT : mode_b;
	assign err_d        = fin ? ST_OK : err_b;
	assign next_d       = fin ? '0 : next_b;
	assign pos_d        = fin ? '0 : pos_b;
	assign open_start_d = fin ? '0 : open_start_b;
	assign open_idx_d   = fin ? '0 : open_idx_b;
	assign sup_none_d   = fin ? 1'b1 : sup_none_b;

	// cache follows the innermost container
	always_comb begin
		c_kind_d  = eff_kind;
		c_start_d = eff_start;
		c_pnone_d = eff_pnone;
		c_par_d   = eff_par;
		c_size_d  = eff_size;
		if (push) begin
			c_kind_d  = open_kind;
			c_start_d = pos_q;
			c_pnone_d = sup_none_q;
			c_par_d   = sup_idx_q;
			c_size_d  = '0;
		end else if ((str_ok || prim_ok) && !sup_none_q) begin
			c_size_d  = size_inc;
		end
	end

	// table: on open, new entry written and the parent's count written back;
	// on close, the parent's entry fetched for the next cycle
	assign tab_ctl.desc_we = push;
	assign tab_ctl.cnt_we  = push && !sup_none_q;
	assign tab_ctl.rd_en   = pop && !eff_pnone;
	assign desc_wdata      = {open_kind, pos_q, sup_none_q, sup_idx_q};
	assign cnt_wdata       = size_inc;
	assign tab_raddr       = eff_par;
	assign reload_d        = tab_ctl.rd_en && !fin;

	jtok_table #(
		.DEPTH  (MAX_TOKENS),
		.DESC_W (DESC_W)
	) u_table (
		.clk        (clk),
		.ctl        (tab_ctl),
		.desc_waddr (next_q[IDX_W-1:0]),
		.desc_wdata (desc_wdata),
		.cnt_waddr  (sup_idx_q),
		.cnt_wdata  (cnt_wdata),
		.raddr      (tab_raddr),
		.desc_rdata (desc_rdata),
		.cnt_rdata  (cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_OUT;
			err_q        <= ST_OK;
			next_q       <= '0;
			pos_q        <= '0;
			open_start_q <= '0;
			open_idx_q   <= '0;
			sup_none_q   <= 1'b1;
			sup_idx_q    <= '0;
			reload_q     <= 1'b0;
		end else begin
			mode_q       <= mode_d;
			err_q        <= err_d;
			next_q       <= next_d;
			pos_q        <= pos_d;
			open_start_q <= open_start_d;
			open_idx_q   <= open_idx_d;
			sup_none_q   <= sup_none_d;
			sup_idx_q    <= sup_idx_b;
			reload_q     <= reload_d;
		end
	end

	always_ff @(posedge clk) begin
		c_kind_q  <= c_kind_d;
		c_start_q <= c_start_d;
		c_pnone_q <= c_pnone_d;
		c_par_q   <= c_par_d;
		c_size_q  <= c_size_d;
	end

	// ---------------------------------------------------------------------
	// Records. Lane 0: primitive ended by this byte. Lane 1: string closed by
	// its quote, or container closed. Lane 2: string or primitive still open
	// at document end. Lane 3: done record.
	// ---------------------------------------------------------------------
	logic [PUSH_LANES-1:0]                lane_v, lane_last;
	logic [PUSH_LANES-1:0]                l_rec;
	logic [PUSH_LANES-1:0][IDX_W-1:0]     l_idx;
	logic [PUSH_LANES-1:0][KIND_W-1:0]    l_kind;
	logic [PUSH_LANES-1:0][PB-1:0]        l_start, l_end;
	logic [PUSH_LANES-1:0][CHILD_W-1:0]   l_size;
	logic [PUSH_LANES-1:0][PAR_W-1:0]     l_par;
	logic [PUSH_LANES-1:0][CNT_W-1:0]     l_total;
	logic [PUSH_LANES-1:0][STATUS_W-1:0]  l_status;
	logic [PUSH_LANES-1:0][REC_W-1:0]     l_data;
	logic [PAR_W-1:0]                     sup_enc, sup_b_enc;

	assign sup_enc   = sup_none_q ? '1 : {1'b0, sup_idx_q};
	assign sup_b_enc = sup_none_b ? '1 : {1'b0, sup_idx_b};

	always_comb begin
		lane_v   = {fin, end_prim || end_str_ok, str_ok || pop, prim_end};
		l_rec    = '0;
		l_idx    = '0;
		l_kind   = '0;
		l_start  = '0;
		l_end    = '0;
		l_size   = '0;
		l_par    = '0;
		l_total  = '0;
		l_status = '0;

		l_idx[0]   = open_idx_q;
		l_kind[0]  = KIND_PRIM;
		l_start[0] = open_start_q;
		l_end[0]   = pos_q;
		l_par[0]   = sup_enc;

		if (pop) begin
			l_idx[1]   = sup_idx_q;
			l_kind[1]  = eff_kind;
			l_start[1] = eff_start;
			l_end[1]   = pos_q + PB'(1);
			l_size[1]  = eff_size;
			l_par[1]   = eff_pnone ? '1 : {1'b0, eff_par};
		end else begin
			l_idx[1]   = next_q[IDX_W-1:0];
			l_kind[1]  = KIND_STRING;
			l_start[1] = open_start_q;
			l_end[1]   = pos_q;
			l_par[1]   = sup_enc;
		end

		l_idx[2]   = end_prim ? open_idx_b : next_b[IDX_W-1:0];
		l_kind[2]  = end_prim ? KIND_PRIM : KIND_STRING;
		l_start[2] = open_start_b;
		l_end[2]   = pos_b;
		l_par[2]   = sup_b_enc;

		l_rec[3]    = REC_DONE;
		l_total[3]  = total;
		l_status[3] = status;

		for (int i = 0; i < PUSH_LANES; i++) begin
			lane_last[i] = lane_v[i] && ((lane_v >> (i + 1)) == '0);
			l_data[i] = {lane_last[i], l_rec[i], l_status[i], l_total[i], l_par[i],
				l_size[i], l_end[i], l_start[i], l_kind[i], l_idx[i]};
		end
	end

	logic             q_room;
	logic [REC_W-1:0] q_out;

	jtok_resq #(
		.WIDTH (REC_W),
		.DEPTH (RESQ_DEPTH),
		.LANES (PUSH_LANES)
	) u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_v    (lane_v),
		.push_data (l_data),
		.in_room   (q_room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (q_out)
	);

	assign s_axis_tready = q_room;
	assign m_axis_tdata  = TDATA_W'(q_out[FIELDS_W-1:0]);
	assign m_axis_tuser  = q_out[FIELDS_W];
	assign m_axis_tlast  = q_out[FIELDS_W+1];

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(lane_v) <= MAX_PUSH)
		else $error("more records than queue headroom from one byte");

	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		reload_q |-> !sup_none_q)
		else $error("table refill with no open container");

	a_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> (pos_q == '0) && (next_q == '0) && sup_none_q && !reload_q)
		else $error("document state not cleared after end");

	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		next_q <= CNT_W'(MAX_TOKENS))
		else $error("token counter past table depth");

endmodule

FILE: verif/json_tokenizer_test.sv
// json_tokenizer_test: self-checking bench for the streaming JSON tokenizer.
// Drives text words, predicts token/done records in-bench, checks each record.
// Depends on jtok_pkg and the json_tokenizer RTL only.
`timescale 1ns / 1ps

module json_tokenizer_test;
	import jtok_pkg::*;

	localparam int TDATA_W        = 64;
	localparam int POS_LIMIT      = (1 << POSITION_BITS_DEF) - 1;
	localparam int SETTLE_CYCLES  = 16;    // pipeline + result queue drain margin
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving anywhere

	// one expected record, same fields as the m_axis word
	typedef struct packed {
		logic              rec_kind;
		logic [5:0]        tok_index;
		logic [1:0]        tok_kind;
		logic [15:0]       start_pos;
		logic [15:0]       end_pos;
		logic [5:0]        children;
		logic signed [6:0] parent;
		logic [6:0]        total;
		logic [2:0]        status;
		logic              last_of_run;
	} token_record_t;

	// bench-driven signals, all known from time zero
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 s_valid   = 1'b0;
	logic [BYTE_W-1:0]    s_data    = '0;
	logic                 s_last    = 1'b0;
	logic                 m_ready   = 1'b0;

	logic                 cfg_ready;
	logic                 s_ready;
	logic                 m_valid;
	logic [TDATA_W-1:0]   m_data;
	logic [0:0]           m_user;
	logic                 m_last;

	json_tokenizer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),    // text_byte
		.s_axis_tlast  (s_last),    // doc_end
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),    // token_index, token_kind, start_pos, end_pos,
		                            // child_count, parent_index, token_total, status, pad
		.m_axis_tuser  (m_user),    // record_kind
		.m_axis_tlast  (m_last)     // last_of_run
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Bench bookkeeping
	// ------------------------------------------------------------------
	token_record_t expected_records[$];
	int            mismatch_count   = 0;
	int            records_seen     = 0;
	int            sender_idle_pct  = 0;
	int            receiver_stall_pct = 0;
	int            idle_run         = 0;

	// ------------------------------------------------------------------
	// Tokenizer predictor state (per document, plus the limit register)
	// ------------------------------------------------------------------
	logic [1:0]   tok_kind     [MAX_TOKENS_DEF];
	int           tok_start    [MAX_TOKENS_DEF];
	int           tok_end      [MAX_TOKENS_DEF];
	int           tok_parent   [MAX_TOKENS_DEF];
	int           tok_children [MAX_TOKENS_DEF];
	int           open_container;   // innermost open object/array, -1 at top level
	int           tokens_used;
	int           text_pos;
	scan_mode_t   mode;
	int           string_start;
	int           prim_slot;
	logic [2:0]   doc_status;
	int           token_limit;

	// scratch text of one random document
	logic [7:0]   doc_text[$];

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	function automatic void reset_document();
		open_container = -1;
		tokens_used    = 0;
		text_pos       = 0;
		mode           = MODE_OUT;
		string_start   = 0;
		prim_slot      = 0;
		doc_status     = ST_OK;
	endfunction

	function automatic void push_token(input int slot);
		token_record_t r;
		r             = '0;
		r.rec_kind    = REC_TOKEN;
		r.tok_index   = slot[5:0];
		r.tok_kind    = tok_kind[slot];
		r.start_pos   = tok_start[slot][15:0];
		r.end_pos     = tok_end[slot][15:0];
		r.children    = tok_children[slot][5:0];
		r.parent      = tok_parent[slot][6:0];   // -1 truncates to 7'h7F
		expected_records.push_back(r);
	endfunction

	// allocate a slot; the parent is recorded now so a close can restore it
	function automatic int claim_slot(input logic [1:0] kind, input int start);
		int limit_now;
		int slot;
		limit_now = (token_limit < MAX_TOKENS_DEF) ? token_limit : MAX_TOKENS_DEF;
		if (tokens_used >= limit_now) begin
			doc_status = ST_NO_TOKENS;
			return -1;
		end
		slot               = tokens_used;
		tokens_used        = tokens_used + 1;
		tok_kind[slot]     = kind;
		tok_start[slot]    = start;
		tok_end[slot]      = start;
		tok_parent[slot]   = open_container;
		tok_children[slot] = 0;
		if (open_container >= 0 && tok_children[open_container] < 63)
			tok_children[open_container]++;
		return slot;
	endfunction

	function automatic bit is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic void close_container(input logic [1:0] kind);
		int slot;
		slot = open_container;
		if (slot < 0 || tok_kind[slot] != kind) begin
			doc_status = ST_BAD_CLOSE;   // unmatched or mismatched close
			return;
		end
		tok_end[slot]  = text_pos + 1;
		open_container = tok_parent[slot];
		push_token(slot);
	endfunction

	function automatic void scan_outside(input logic [7:0] c);
		int slot;
		if (c == CH_LBRACE || c == CH_LBRACK) begin
			slot = claim_slot((c == CH_LBRACE) ? KIND_OBJECT : KIND_ARRAY, text_pos);
			if (slot >= 0)
				open_container = slot;
		end else if (c == CH_RBRACE || c == CH_RBRACK) begin
			close_container((c == CH_RBRACE) ? KIND_OBJECT : KIND_ARRAY);
		end else if (c == CH_QUOTE) begin
			string_start = text_pos + 1;
			mode         = MODE_STR;
		end else if (is_space(c) || c == CH_COLON || c == CH_COMMA) begin
			// separator, skipped
		end else if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS || c == CH_LOW_T
				|| c == CH_LOW_F || c == CH_LOW_N) begin
			slot = claim_slot(KIND_PRIM, text_pos);
			if (slot >= 0) begin
				prim_slot = slot;
				mode      = MODE_PRIM;
			end
		end else begin
			doc_status = ST_INVALID;
		end
	endfunction

	function automatic void take_byte(input logic [7:0] c);
		int slot;
		if (text_pos >= POS_LIMIT) begin
			doc_status = ST_TOO_LONG;   // byte not taken, position frozen
			return;
		end
		case (mode)
			MODE_ESC: mode = MODE_STR;
			MODE_STR: begin
				if (c == CH_BSLASH) begin
					mode = MODE_ESC;
				end else if (c == CH_QUOTE) begin
					mode = MODE_OUT;
					slot = claim_slot(KIND_STRING, string_start);
					if (slot >= 0) begin
						tok_end[slot] = text_pos;
						push_token(slot);
					end
				end
			end
			MODE_PRIM: begin
				// terminator closes the primitive, then is scanned as usual
				if (is_space(c) || c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE) begin
					mode               = MODE_OUT;
					tok_end[prim_slot] = text_pos;
					push_token(prim_slot);
					scan_outside(c);
				end
			end
			default: scan_outside(c);
		endcase
		text_pos++;
	endfunction

	function automatic void close_document();
		int            slot;
		token_record_t r;
		// an open string or primitive closes at the document length, unless errored
		if (doc_status == ST_OK) begin
			if (mode == MODE_PRIM) begin
				tok_end[prim_slot] = text_pos;
				push_token(prim_slot);
			end else if (mode == MODE_STR || mode == MODE_ESC) begin
				slot = claim_slot(KIND_STRING, string_start);
				if (slot >= 0) begin
					tok_end[slot] = text_pos;
					push_token(slot);
				end
			end
		end
		r          = '0;
		r.rec_kind = REC_DONE;
		r.total    = tokens_used[6:0];
		r.status   = doc_status;
		expected_records.push_back(r);
		reset_document();
	endfunction

	// records caused by one accepted text word
	function automatic void tokenize_byte(input logic [7:0] c, input logic last);
		int            queued;
		token_record_t r;
		queued = expected_records.size();
		if (c == CH_NUL) begin
			close_document();
		end else begin
			if (doc_status == ST_OK)
				take_byte(c);
			if (last)
				close_document();
		end
		if (expected_records.size() > queued) begin
			r             = expected_records.pop_back();
			r.last_of_run = 1'b1;
			expected_records.push_back(r);
		end
	endfunction

	// ------------------------------------------------------------------
	// Record checker: every accepted m_axis word against the oldest expectation
	// ------------------------------------------------------------------
	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("record %0d %s: got %0d expected %0d",
				records_seen, name, got, want));
	endtask

	task automatic check_record();
		token_record_t want;
		if (expected_records.size() == 0) begin
			report_mismatch($sformatf("record %0d unexpected, tuser %0d tdata %h",
				records_seen, m_user, m_data));
		end else begin
			want = expected_records.pop_front();
			if ($isunknown({m_user, m_last, m_data[62:0]}))
				report_mismatch($sformatf("record %0d has unknown bits", records_seen));
			compare_field("record_kind", m_user[0], want.rec_kind);
			compare_field("token_index", m_data[5:0], want.tok_index);
			compare_field("token_kind", m_data[7:6], want.tok_kind);
			compare_field("start_pos", m_data[23:8], want.start_pos);
			compare_field("end_pos", m_data[39:24], want.end_pos);
			compare_field("child_count", m_data[45:40], want.children);
			compare_field("parent_index", $signed(m_data[52:46]), want.parent);
			compare_field("token_total", m_data[59:53], want.total);
			compare_field("status", m_data[62:60], want.status);
			compare_field("last_of_run", m_last, want.last_of_run);
		end
		records_seen++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_valid && m_ready)
			check_record();
	end

	// receiver backpressure, rate set per phase
	always @(posedge clk) begin
		m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// watchdog: run of cycles where no word moves on any channel
	always @(posedge clk) begin
		if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
	end

	initial begin
		wait (idle_run >= WATCHDOG_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// One text word. valid stays up after acceptance; the next call either
	// reuses it or drops it for a gap, so only one update lands per edge.
	task automatic send_word(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_valid <= 1'b0;
			@(posedge clk);
		end
		s_valid <= 1'b1;
		s_data  <= b;
		s_last  <= last;
		do @(posedge clk); while (!s_ready);
		tokenize_byte(b, last);
	endtask

	task automatic send_text(input string text, input bit zero_end);
		for (int i = 0; i < text.len(); i++)
			send_word(text[i], !zero_end && (i == text.len() - 1));
		if (zero_end)
			send_word(CH_NUL, 1'b0);
	endtask

	// stop sending, wait for all records, then let the pipeline settle
	task automatic drain_and_settle();
		s_valid <= 1'b0;
		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_token_limit(input int value);
		cfg_valid <= 1'b1;
		cfg_data  <= value[CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		token_limit = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		sender_idle_pct    = sender_pct;
		receiver_stall_pct = receiver_pct;
	endtask

	// ------------------------------------------------------------------
	// Random document builder (iterative, containers nest two deep)
	// ------------------------------------------------------------------
	function automatic void add_space();
		if ($urandom_range(0, 2) == 0)
			case ($urandom_range(0, 3))
				0: doc_text.push_back(CH_SPACE);
				1: doc_text.push_back(CH_TAB);
				2: doc_text.push_back(CH_CR);
				default: doc_text.push_back(CH_LF);
			endcase
	endfunction

	function automatic void add_string();
		logic [7:0] b;
		doc_text.push_back(CH_QUOTE);
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 6) == 0) begin
				// escape: the next byte is content whatever it is
				doc_text.push_back(CH_BSLASH);
				doc_text.push_back(8'($urandom_range(1, 255)));
			end else begin
				do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
				doc_text.push_back(b);
			end
		end
		doc_text.push_back(CH_QUOTE);
	endfunction

	function automatic void add_primitive();
		string lead = "0123456789-tfn";
		string body = "0123456789.eE+alrsu\"{[";   // quotes and openers stay inside
		doc_text.push_back(lead[$urandom_range(0, lead.len() - 1)]);
		repeat ($urandom_range(0, 3))
			doc_text.push_back(body[$urandom_range(0, body.len() - 1)]);
	endfunction

	function automatic void build_document();
		int  open_kind[$];      // 0 object, 1 array
		int  members_left[$];
		bit  has_member[$];
		bit  need_value;
		int  top;
		int  pick;
		doc_text.delete();
		need_value = 1'b1;
		forever begin
			if (need_value) begin
				pick = (open_kind.size() < 2) ? $urandom_range(0, 3) : $urandom_range(2, 3);
				if (pick < 2) begin
					doc_text.push_back((pick == 0) ? CH_LBRACE : CH_LBRACK);
					open_kind.push_back(pick);
					members_left.push_back($urandom_range(0, 2));
					has_member.push_back(1'b0);
				end else if (pick == 2) begin
					add_string();
				end else begin
					add_primitive();
				end
				need_value = 1'b0;
			end else begin
				if (open_kind.size() == 0)
					break;
				top = open_kind.size() - 1;
				if (members_left[top] == 0) begin
					add_space();
					doc_text.push_back((open_kind[top] == 0) ? CH_RBRACE : CH_RBRACK);
					void'(open_kind.pop_back());
					void'(members_left.pop_back());
					void'(has_member.pop_back());
				end else begin
					if (has_member[top])
						doc_text.push_back(CH_COMMA);
					add_space();
					if (open_kind[top] == 0) begin
						add_string();
						add_space();
						doc_text.push_back(CH_COLON);
						add_space();
					end
					members_left[top]--;
					has_member[top] = 1'b1;
					need_value      = 1'b1;
				end
			end
		end
		// noise: a minority of documents are broken on purpose
		if ($urandom_range(0, 5) == 0)
			case ($urandom_range(0, 2))
				0: doc_text[$urandom_range(0, doc_text.size() - 1)] = 8'($urandom_range(1, 255));
				1: doc_text.insert($urandom_range(0, doc_text.size()), 8'($urandom_range(1, 255)));
				default: while (doc_text.size() > 1 && $urandom_range(0, 2) != 0)
					void'(doc_text.pop_back());
			endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// objects, arrays, strings, primitives and nesting at the reset limit
	task automatic test_basic_tokens();
		send_text("{\"a\":[1,t]}", 1'b0);
		send_text("-9", 1'b0);          // primitive open at the end: end is exclusive
		drain_and_settle();
	endtask

	// backslash followed by the zero byte; open string closed at the end
	task automatic test_string_escapes();
		send_text("\"\\", 1'b1);
		drain_and_settle();
	endtask

	task automatic test_error_paths();
		send_text("[}", 1'b0);          // mismatched close
		send_text("]", 1'b0);           // close with nothing open
		send_text("?{", 1'b1);          // invalid byte, then input ignored
		send_word(CH_NUL, 1'b1);        // empty document, zero byte with tlast
		drain_and_settle();
	endtask

	task automatic test_token_limit();
		write_token_limit(1);
		send_text("[n]", 1'b0);         // primitive cannot allocate
		send_text("[\"b\"]", 1'b1);     // string cannot allocate at its closing quote
		drain_and_settle();
	endtask

	task automatic test_random_documents(input int sender_pct, input int receiver_pct,
			input int limit, input int word_target);
		int sent;
		int ending;
		set_idling(sender_pct, receiver_pct);
		write_token_limit(limit);
		sent = 0;
		while (sent < word_target) begin
			if ($urandom_range(0, 11) == 0) begin
				send_word(CH_NUL, 1'($urandom_range(0, 1)));
				sent++;
			end else begin
				build_document();
				ending = $urandom_range(0, 2);
				foreach (doc_text[i])
					send_word(doc_text[i], ending == 0 && i == doc_text.size() - 1);
				if (ending != 0)
					send_word(CH_NUL, ending == 2);
				sent += doc_text.size() + (ending != 0);
			end
		end
		drain_and_settle();
	endtask

	initial begin
		token_limit = MAX_TOKENS_RST;
		reset_document();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_tokens();
		test_string_escapes();
		test_error_paths();
		test_token_limit();
		test_random_documents(0, 0, MAX_TOKENS_DEF, 25);
		test_random_documents(84, 0, 5, 25);
		test_random_documents(0, 84, MAX_TOKENS_DEF, 25);
		test_random_documents(6, 6, 2, 25);

		if (expected_records.size() != 0)
			report_mismatch($sformatf("%0d records never arrived", expected_records.size()));
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
design/jtok_pkg.sv
design/jtok_table.sv
design/jtok_resq.sv
design/json_tokenizer.sv
verif/json_tokenizer_test.sv
